// ===== design/checkerboard_square_scan_unit_defines.svh =====
// Assertion macros for the checkerboard square scan unit.
`ifndef CHECKERBOARD_SQUARE_SCAN_UNIT_DEFINES_SVH
`define CHECKERBOARD_SQUARE_SCAN_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define CSSU_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cssu same-cycle check failed");
`define CSSU_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cssu next-cycle check failed");
`else
`define CSSU_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define CSSU_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== design/cssu_pkg.sv =====
// Shared types and constants of the checkerboard square scan unit.
package cssu_pkg;

  localparam int SIDE_W = 12;
  localparam int COLS_W = 12;

  typedef logic [SIDE_W-1:0] side_t;
  typedef logic [COLS_W-1:0] cols_t;

  localparam side_t SIDE_ONE = side_t'(1);
  localparam side_t SIDE_MAX = '1;
  localparam cols_t COLUMNS_RESET = cols_t'(2048);

  // One line store entry: cell value and square side of the row above.
  typedef struct packed {
    logic  bit_val;
    side_t side;
  } line_entry_t;

endpackage

// ===== design/cssu_if.sv =====
// Item channel interfaces of the checkerboard square scan unit.
interface cssu_in_if;
  logic valid;
  logic ready;
  logic cell_req;
  logic last_cell;

  modport source (output valid, output cell_req, output last_cell, input ready);
  modport sink (input valid, input cell_req, input last_cell, output ready);
endinterface

interface cssu_out_if;
  logic           valid;
  logic           ready;
  cssu_pkg::side_t side_here;
  cssu_pkg::side_t best_side;
  logic           is_final;

  modport source (output valid, output side_here, output best_side, output is_final,
                  input ready);
  modport sink (input valid, input side_here, input best_side, input is_final,
                output ready);
endinterface

// ===== design/cssu_line_store.sv =====
// Line store holding the previous row's cells and sides, with write forwarding.
module cssu_line_store #(
  parameter int DEPTH = 2048
) (
  input  logic                          clk,
  input  logic                          rd_en,
  input  logic [$clog2(DEPTH)-1:0]      rd_addr,
  output cssu_pkg::line_entry_t         rd_data,
  input  logic                          wr_en,
  input  logic [$clog2(DEPTH)-1:0]      wr_addr,
  input  cssu_pkg::line_entry_t         wr_data
);

  cssu_pkg::line_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds until the next read; a same-edge write to the entry wins.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data <= wr_data;
      end else begin
        rd_data <= mem[rd_addr];
      end
    end
  end

endmodule

// ===== design/checkerboard_square_scan_unit.sv =====
// Checkerboard square scan unit: top level.
// Cells of a binary matrix arrive in raster order on in_ch, one item per cell,
// last_cell marking the final cell of a matrix. For every cell one item leaves
// on out_ch: side_here, the side of the largest checkerboard square whose lower
// right corner is this cell, best_side, the largest side so far in the matrix,
// and is_final, set on the result of the final cell.
// cfg_wr_en/cfg_wr_data write the row length (columns); 0 acts as 1 and values
// above MAX_COLUMNS act as MAX_COLUMNS. Write it only while no item is in flight.
// A cell enters the compute stage at accept, its result then the output register.
// Throughput: one item per cycle while out_ch does not stall; per cell, one line
// store read at accept and one write as its result registers, one port per side.
// Reset (rst, synchronous) empties the pipeline, restarts the scan at row 0,
// column 0 and sets columns to 2048. The line store is not cleared; the first
// row of each matrix never uses it.
// When out_ch stalls, one result waits in the output register and one more
// cell is held in the compute stage; in_ch.ready drops only when both are full.
`include "checkerboard_square_scan_unit_defines.svh"

module checkerboard_square_scan_unit #(
  parameter int MAX_COLUMNS = 2048
) (
  input  logic                   clk,
  input  logic                   rst,
  cssu_in_if.sink                in_ch,
  cssu_out_if.source             out_ch,
  input  logic                   cfg_wr_en,
  input  cssu_pkg::cols_t        cfg_wr_data
);

  localparam int IDX_W = $clog2(MAX_COLUMNS);
  localparam int CNT_W = IDX_W + 1;

  // front (accept side) scan position
  cssu_pkg::cols_t    columns;
  logic [IDX_W-1:0]   col_idx;
  logic               first_row;

  // compute stage
  logic               s1_valid;
  logic               s1_cell;
  logic               s1_last;
  logic               s1_first;
  logic [IDX_W-1:0]   s1_col;

  // window registers
  logic               left_cell;
  cssu_pkg::side_t    left_side;
  logic               diag_cell;
  cssu_pkg::side_t    diag_side;
  cssu_pkg::side_t    running_best;

  // output register
  logic               out_valid;
  cssu_pkg::side_t    out_side;
  cssu_pkg::side_t    out_best;
  logic               out_final;

  logic               in_acc;
  logic               out_free;
  logic               s1_adv;
  logic [31:0]        cols32;
  logic [31:0]        ncols32;
  logic [CNT_W-1:0]   ncols;
  logic [CNT_W-1:0]   col_inc;
  logic               wrap;
  cssu_pkg::line_entry_t up;
  cssu_pkg::line_entry_t wr_entry;
  logic               extend;
  cssu_pkg::side_t    min_lu;
  cssu_pkg::side_t    min3;
  cssu_pkg::side_t    side_inc;
  cssu_pkg::side_t    side;
  cssu_pkg::side_t    best_next;

  assign out_free = !out_valid || out_ch.ready;
  assign s1_adv   = s1_valid && out_free;
  assign in_ch.ready = !s1_valid || s1_adv;
  assign in_acc   = in_ch.valid && in_ch.ready;

  always_comb begin
    cols32 = 32'(columns);
    if (cols32 == 32'd0) begin
      ncols32 = 32'd1;
    end else if (cols32 > 32'(MAX_COLUMNS)) begin
      ncols32 = 32'(MAX_COLUMNS);
    end else begin
      ncols32 = cols32;
    end
    ncols   = CNT_W'(ncols32);
    col_inc = {1'b0, col_idx} + CNT_W'(1);
    wrap    = col_inc >= ncols;
  end

  cssu_line_store #(
    .DEPTH (MAX_COLUMNS)
  ) u_line_store (
    .clk     (clk),
    .rd_en   (in_acc),
    .rd_addr (col_idx),
    .rd_data (up),
    .wr_en   (s1_adv),
    .wr_addr (s1_col),
    .wr_data (wr_entry)
  );

  // side rule: grow when the cell matches the diagonal and differs from left and up
  always_comb begin
    extend   = (s1_cell == diag_cell) && (s1_cell != left_cell) && (s1_cell != up.bit_val);
    min_lu   = (left_side < up.side) ? left_side : up.side;
    min3     = (diag_side < min_lu) ? diag_side : min_lu;
    side_inc = (min3 == cssu_pkg::SIDE_MAX) ? cssu_pkg::SIDE_MAX : min3 + cssu_pkg::SIDE_ONE;
    if (s1_first || (s1_col == '0) || !extend) begin
      side = cssu_pkg::SIDE_ONE;
    end else begin
      side = side_inc;
    end
    best_next = (side > running_best) ? side : running_best;
    wr_entry.bit_val = s1_cell;
    wr_entry.side    = side;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      columns <= cssu_pkg::COLUMNS_RESET;
    end else if (cfg_wr_en) begin
      columns <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_idx   <= '0;
      first_row <= 1'b1;
    end else if (in_acc) begin
      if (in_ch.last_cell) begin
        col_idx   <= '0;
        first_row <= 1'b1;
      end else if (wrap) begin
        col_idx   <= '0;
        first_row <= 1'b0;
      end else begin
        col_idx   <= col_inc[IDX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cell  <= in_ch.cell_req;
      s1_last  <= in_ch.last_cell;
      s1_first <= first_row;
      s1_col   <= col_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_cell    <= 1'b0;
      left_side    <= cssu_pkg::SIDE_ONE;
      diag_cell    <= 1'b0;
      diag_side    <= cssu_pkg::SIDE_ONE;
      running_best <= cssu_pkg::SIDE_ONE;
    end else if (s1_adv) begin
      if (s1_last) begin
        left_cell    <= 1'b0;
        left_side    <= cssu_pkg::SIDE_ONE;
        diag_cell    <= 1'b0;
        diag_side    <= cssu_pkg::SIDE_ONE;
        running_best <= cssu_pkg::SIDE_ONE;
      end else begin
        left_cell    <= s1_cell;
        left_side    <= side;
        diag_cell    <= up.bit_val;
        diag_side    <= up.side;
        running_best <= best_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_side  <= side;
      out_best  <= best_next;
      out_final <= s1_last;
    end
  end

  assign out_ch.valid     = out_valid;
  assign out_ch.side_here = out_side;
  assign out_ch.best_side = out_best;
  assign out_ch.is_final  = out_final;

  `CSSU_ASSERT_SAME(a_best_covers_side, clk, rst, out_valid, (out_side != '0) && (out_best >= out_side))
  `CSSU_ASSERT_NEXT(a_stage_holds, clk, rst, s1_valid && !out_free, s1_valid)
  `CSSU_ASSERT_NEXT(a_last_restarts, clk, rst, in_acc && in_ch.last_cell, (col_idx == '0) && first_row)
  `CSSU_ASSERT_NEXT(a_col_steps, clk, rst, in_acc && !in_ch.last_cell && !wrap, col_idx == $past(col_inc[IDX_W-1:0]))

endmodule
